FILE: design/frame_map_boundary_policy_defines.svh
// Assertion macros for the frame map boundary policy block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef FRAME_MAP_BOUNDARY_POLICY_DEFINES_SVH
`define FRAME_MAP_BOUNDARY_POLICY_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every rising edge once reset is released
`define FMBP_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("fmbp: assertion failed");
// Check on every rising edge, reset cycles included
`define FMBP_ASSERT_RST(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("fmbp: assertion failed");
`else
`define FMBP_ASSERT(lbl, clk_s, rst_s, prop)
`define FMBP_ASSERT_RST(lbl, clk_s, prop)
`endif

`endif

FILE: design/fmbp_pkg.sv
// Shared types, codes and helpers of the frame map boundary policy block.
// Used by fmbp_mult, fmbp_holes and frame_map_boundary_policy; no dependencies.
package fmbp_pkg;

  localparam int FRAME_W       = 64;
  localparam int IDX_W         = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int STATUS_W      = 3;
  localparam int POL_W         = 2;
  localparam int IN_DATA_W     = 200;
  localparam int OUT_DATA_W    = 136;
  localparam int MAX_HOLES_DEF = 16;
  localparam int MUL_CNT_W     = $clog2(FRAME_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BEFORE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_AFTER   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSING = 3'd7;

  // Boundary policy codes (the unused code acts as error)
  localparam logic [POL_W-1:0] POL_ERROR = 2'd0;
  localparam logic [POL_W-1:0] POL_HOLD  = 2'd1;
  localparam logic [POL_W-1:0] POL_BLACK = 2'd2;

  // Missing-frame modes (the unused code acts as error)
  localparam logic [POL_W-1:0] MISS_IGNORE = 2'd0;
  localparam logic [POL_W-1:0] MISS_ERROR  = 2'd1;
  localparam logic [POL_W-1:0] MISS_BLACK  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BEFORE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_AFTER   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FAIL    = 3'd4;

  // Hole table write request
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] last;
    logic               valid;
  } fmbp_hole_wr_t;

  // Hole scan status
  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } fmbp_scan_t;

  // Signed less-than on two's complement frame numbers
  function automatic logic slt(input logic [FRAME_W-1:0] a, input logic [FRAME_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

FILE: design/fmbp_mult.sv
// Bit-serial unsigned multiplier, one multiplier bit per cycle, full double-width product.
// Depends on fmbp_pkg.
`include "frame_map_boundary_policy_defines.svh"

module fmbp_mult import fmbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [FRAME_W-1:0] a,
  input  logic [FRAME_W-1:0] b,
  output logic               busy,
  output logic               done,
  output logic [FRAME_W-1:0] hi,
  output logic [FRAME_W-1:0] lo
);

  logic [FRAME_W-1:0]   b_r;
  logic [MUL_CNT_W-1:0] cnt;
  logic [FRAME_W:0]     psum;
  logic                 last;

  // Add the multiplicand when the current multiplier bit is set
  assign psum = {1'b0, hi} + (lo[0] ? {1'b0, b_r} : {(FRAME_W + 1){1'b0}});
  assign last = (cnt == MUL_CNT_W'(FRAME_W - 1));

  // Control: count the multiplier bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the partial product right one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      hi  <= '0;
      lo  <= a;
      b_r <= b;
    end else if (busy) begin
      hi <= psum[FRAME_W:1];
      lo <= {psum[0], lo[FRAME_W-1:1]};
    end
  end

  `FMBP_ASSERT(a_start_when_free, clk, rst, start |-> !busy)
  `FMBP_ASSERT(a_start_runs, clk, rst, start |=> busy && cnt == '0)
  `FMBP_ASSERT(a_done_after_last, clk, rst, done |-> !busy && $past(busy && last))

endmodule

FILE: design/fmbp_holes.sv
// Missing-frame interval table with a serial scan, one entry per cycle.
// Depends on fmbp_pkg.
`include "frame_map_boundary_policy_defines.svh"

module fmbp_holes import fmbp_pkg::*; #(
  parameter int MAX_HOLES = MAX_HOLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  fmbp_hole_wr_t      wr,
  input  logic               scan_start,
  input  logic [FRAME_W-1:0] target,
  output fmbp_scan_t         scan
);

  localparam int AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int CW = $clog2(MAX_HOLES + 1);

  logic [FRAME_W-1:0]   start_mem [MAX_HOLES];
  logic [FRAME_W-1:0]   end_mem   [MAX_HOLES];
  logic [MAX_HOLES-1:0] active;

  logic               wr_ok;
  logic [AW-1:0]      wr_addr;
  logic [CW-1:0]      cnt;
  logic [AW-1:0]      raddr;
  logic               scanning;
  logic               last_issue;
  logic               p1;
  logic               p1_last;
  logic               act_d;
  logic [FRAME_W-1:0] start_d;
  logic [FRAME_W-1:0] end_d;
  logic               match;
  logic               hit;
  logic               done;

  // Drop writes beyond the table depth
  assign wr_ok      = wr.en && (32'(wr.idx) < MAX_HOLES);
  assign wr_addr    = AW'(wr.idx);
  assign raddr      = cnt[AW-1:0];
  assign last_issue = (cnt == CW'(MAX_HOLES - 1));

  // Interval storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      start_mem[wr_addr] <= wr.first;
      end_mem[wr_addr]   <= wr.last;
    end
    if (scanning) begin
      start_d <= start_mem[raddr];
      end_d   <= end_mem[raddr];
    end
  end

  // Entry valid bits and scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= '0;
      scanning <= 1'b0;
      cnt      <= '0;
      p1       <= 1'b0;
      p1_last  <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (wr_ok) begin
        active[wr_addr] <= wr.valid;
      end
      done    <= p1 && p1_last;
      p1      <= scanning;
      p1_last <= scanning && last_issue;
      if (scan_start) begin
        scanning <= 1'b1;
        cnt      <= '0;
      end else if (scanning) begin
        cnt <= cnt + 1'b1;
        if (last_issue) begin
          scanning <= 1'b0;
        end
      end
    end
  end

  // Compare the entry read last cycle; an inverted interval never matches
  assign match = act_d && !slt(target, start_d) && !slt(end_d, target);

  always_ff @(posedge clk) begin
    if (scanning) begin
      act_d <= active[raddr];
    end
    if (scan_start) begin
      hit <= 1'b0;
    end else if (p1) begin
      hit <= hit | match;
    end
  end

  assign scan.busy = scanning | p1;
  assign scan.done = done;
  assign scan.hit  = hit;

  `FMBP_ASSERT(a_start_when_free, clk, rst, scan_start |-> !scan.busy)
  `FMBP_ASSERT(a_no_write_in_scan, clk, rst, !(wr.en && (scan.busy || scan_start)))
  `FMBP_ASSERT(a_done_after_last, clk, rst, done |-> $past(p1 && p1_last) && !scanning)

endmodule

FILE: design/frame_map_boundary_policy.sv
// A table write returns nothing; a time request passes the multiply, map, add and range states,
// then the hole table scan when one is needed, and the result register, and is held longer while the
// previous result still waits. Throughput: one request at a time, set by the 64-step
// bit-serial multiplier and the one-entry-per-cycle hole scan. Reset: synchronous, active
// high; it restores the register defaults and clears every hole valid bit at once.
// Top level: config registers, request sequencer, result register; uses fmbp_mult, fmbp_holes.
`include "frame_map_boundary_policy_defines.svh"

module frame_map_boundary_policy import fmbp_pkg::*; #(
  parameter int MAX_HOLES = MAX_HOLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [63:0] local_time, [67:64] hole_index, [131:68] hole_first,
  // [195:132] hole_last, [196] hole_valid, [199:197] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                  s_axis_tuser,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] status, [66:3] source_frame, [130:67] read_frame, [131] transparent_black,
  // [132] policy_error, [133] hold_applied, [135:134] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [FRAME_W-1:0]    cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_MAP   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_RANGE = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Configuration registers
  logic [FRAME_W-1:0] frame_offset;
  logic [FRAME_W-1:0] frame_step;
  logic [FRAME_W-1:0] range_first;
  logic [FRAME_W-1:0] range_last;
  logic               bounds_active;
  logic [POL_W-1:0]   before_policy;
  logic [POL_W-1:0]   after_policy;
  logic [POL_W-1:0]   missing_mode;

  logic [2:0]         state;
  logic               in_xfer;
  logic               req_xfer;
  logic [FRAME_W-1:0] in_time;

  logic               neg;
  logic               zero_step;
  logic               mul_start;
  logic [FRAME_W-1:0] mul_a;
  logic [FRAME_W-1:0] mul_b;
  logic               mul_busy;
  logic               mul_done;
  logic [FRAME_W-1:0] mul_hi;
  logic [FRAME_W-1:0] mul_lo;

  logic [FRAME_W-1:0] prod;
  logic               fail;
  logic [FRAME_W-1:0] src;
  logic [FRAME_W-1:0] sum;
  logic               mul_ovf;
  logic               add_ovf;

  logic               before_q;
  logic               inside_q;
  logic               hit_q;
  logic [FRAME_W-1:0] target;
  logic               rng_before;
  logic               rng_inside;
  logic [POL_W-1:0]   rng_pol;
  logic               validated;
  logic               need_scan;

  fmbp_hole_wr_t      hole_wr;
  fmbp_scan_t         scan;
  logic               scan_start;

  logic               out_load;
  logic [STATUS_W-1:0] out_status;
  logic [FRAME_W-1:0] out_src;
  logic [FRAME_W-1:0] out_read;
  logic               out_black;
  logic               out_err;
  logic               out_hold;
  logic [STATUS_W-1:0] res_status;
  logic [FRAME_W-1:0] res_src;
  logic [FRAME_W-1:0] res_read;
  logic               res_black;
  logic               res_err;
  logic               res_hold;
  logic [FRAME_W-1:0] edge_frame;
  logic [POL_W-1:0]   pol;
  logic               miss_black;

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign cfg_ready     = !rst;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign req_xfer      = in_xfer && s_axis_tuser;
  assign in_time       = s_axis_tdata[63:0];

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_offset  <= '0;
      frame_step    <= FRAME_W'(1);
      range_first   <= '0;
      range_last    <= '0;
      bounds_active <= 1'b0;
      before_policy <= POL_ERROR;
      after_policy  <= POL_ERROR;
      missing_mode  <= MISS_IGNORE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFSET:  frame_offset  <= cfg_data;
        CFG_STEP:    frame_step    <= cfg_data;
        CFG_FIRST:   range_first   <= cfg_data;
        CFG_LAST:    range_last    <= cfg_data;
        CFG_BOUNDS:  bounds_active <= cfg_data[0];
        CFG_BEFORE:  before_policy <= cfg_data[POL_W-1:0];
        CFG_AFTER:   after_policy  <= cfg_data[POL_W-1:0];
        CFG_MISSING: missing_mode  <= cfg_data[POL_W-1:0];
      endcase
    end
  end

  // Hole table writes come straight from the request stream
  assign hole_wr.en    = in_xfer && !s_axis_tuser;
  assign hole_wr.idx   = s_axis_tdata[67:64];
  assign hole_wr.first = s_axis_tdata[131:68];
  assign hole_wr.last  = s_axis_tdata[195:132];
  assign hole_wr.valid = s_axis_tdata[196];

  // Multiply magnitudes; the sign is put back afterwards
  assign mul_start = req_xfer;
  assign mul_a     = in_time[FRAME_W-1] ? (FRAME_W'(0) - in_time) : in_time;
  assign mul_b     = frame_step[FRAME_W-1] ? (FRAME_W'(0) - frame_step) : frame_step;

  fmbp_mult u_mult (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .hi    (mul_hi),
    .lo    (mul_lo)
  );

  fmbp_holes #(.MAX_HOLES(MAX_HOLES)) u_holes (
    .clk        (clk),
    .rst        (rst),
    .wr         (hole_wr),
    .scan_start (scan_start),
    .target     (target),
    .scan       (scan)
  );

  // Overflow checks of the signed product and the offset add
  assign mul_ovf = (mul_hi != '0) ||
                   (mul_lo[FRAME_W-1] && (!neg || (mul_lo[FRAME_W-2:0] != '0)));
  assign sum     = frame_offset + prod;
  assign add_ovf = (frame_offset[FRAME_W-1] == prod[FRAME_W-1]) &&
                   (sum[FRAME_W-1] != prod[FRAME_W-1]);

  // Range classification
  assign validated  = (missing_mode != MISS_IGNORE);
  assign rng_before = slt(src, range_first);
  assign rng_inside = !rng_before && !slt(range_last, src);
  assign rng_pol    = rng_before ? before_policy : after_policy;
  assign need_scan  = bounds_active && validated && (rng_inside || (rng_pol == POL_HOLD));
  assign scan_start = (state == S_RANGE) && !fail && need_scan;

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (req_xfer) state <= S_MUL;
        S_MUL:   if (mul_done) state <= S_MAP;
        S_MAP:   state <= S_ADD;
        S_ADD:   state <= S_RANGE;
        S_RANGE: state <= scan_start ? S_SCAN : S_OUT;
        S_SCAN:  if (scan.done) state <= S_OUT;
        S_OUT:   if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request datapath
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      neg       <= in_time[FRAME_W-1] ^ frame_step[FRAME_W-1];
      zero_step <= (frame_step == '0);
    end
    if (state == S_MAP) begin
      prod <= neg ? (FRAME_W'(0) - mul_lo) : mul_lo;
      fail <= zero_step || mul_ovf;
    end
    if (state == S_ADD) begin
      fail <= fail || add_ovf;
      src  <= (fail || add_ovf) ? '0 : sum;
    end
    if (state == S_RANGE) begin
      before_q <= rng_before;
      inside_q <= rng_inside;
      target   <= rng_inside ? src : (rng_before ? range_first : range_last);
      hit_q    <= 1'b0;
    end
    if ((state == S_SCAN) && scan.done) begin
      hit_q <= scan.hit;
    end
  end

  // Apply the boundary and missing-frame policy
  assign pol        = before_q ? before_policy : after_policy;
  assign edge_frame = before_q ? range_first : range_last;
  assign miss_black = (missing_mode == MISS_BLACK);

  always_comb begin
    res_status = ST_OK;
    res_src    = src;
    res_read   = src;
    res_black  = 1'b0;
    res_err    = 1'b0;
    res_hold   = 1'b0;
    if (fail) begin
      res_status = ST_FAIL;
      res_src    = '0;
      res_read   = '0;
    end else if (bounds_active) begin
      if (!inside_q) begin
        res_status = before_q ? ST_BEFORE : ST_AFTER;
        unique case (pol)
          POL_BLACK: res_black = 1'b1;
          POL_HOLD: begin
            if (hit_q) begin
              res_status = ST_MISSING;
              res_err    = !miss_black;
              res_black  = miss_black;
            end else begin
              res_read = edge_frame;
              res_hold = 1'b1;
            end
          end
          default: res_err = 1'b1;
        endcase
      end else if (hit_q) begin
        res_status = ST_MISSING;
        res_err    = !miss_black;
        res_black  = miss_black;
      end
    end
  end

  // Result register: load when empty or being drained
  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_src    <= res_src;
      out_read   <= res_read;
      out_black  <= res_black;
      out_err    <= res_err;
      out_hold   <= res_hold;
    end
  end

  assign m_axis_tdata = {2'b00, out_hold, out_err, out_black, out_read, out_src, out_status};

  `FMBP_ASSERT_RST(a_reset_idle, clk, rst |=> state == S_IDLE && !m_axis_tvalid)
  `FMBP_ASSERT(a_req_starts_mul, clk, rst, req_xfer |=> state == S_MUL && mul_busy)
  `FMBP_ASSERT(a_fail_clean, clk, rst,
    m_axis_tvalid && out_status == ST_FAIL |-> out_src == '0 && out_read == '0 && !out_hold)
  `FMBP_ASSERT(a_hold_at_bound, clk, rst,
    m_axis_tvalid && out_hold |-> (out_status == ST_BEFORE || out_status == ST_AFTER))
  `FMBP_ASSERT(a_black_xor_err, clk, rst, m_axis_tvalid |-> !(out_black && out_err))

endmodule

FILE: verif/tb_frame_map_boundary_policy.sv
// Testbench for frame_map_boundary_policy: drives hole-table writes and time requests,
// predicts each resolved frame and compares every result transfer field by field.
// Depends on fmbp_pkg and the frame_map_boundary_policy RTL.
module tb_frame_map_boundary_policy import fmbp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [63:0] FRAME_MAX   = 64'h7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] FRAME_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [1:0]         POL_UNUSED  = 2'd3;
  localparam logic [1:0]         MISS_UNUSED = 2'd3;
  localparam int                 SETTLE_CYC  = 100;

  typedef struct packed {
    logic        kind;
    logic [63:0] ltime;
    logic [3:0]  slot;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        live;
    logic        drain_first;
  } frame_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] src;
    logic [63:0] rd;
    logic        black;
    logic        err;
    logic        hold;
  } frame_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [FRAME_W-1:0]    cfg_data = '0;

  // Mirror of the mapping registers, updated once a full register set is written
  logic signed [63:0] map_offset = 0;
  logic signed [63:0] map_step   = 1;
  logic signed [63:0] map_first  = 0;
  logic signed [63:0] map_last   = 0;
  logic               map_bounds = 1'b0;
  logic [1:0]         map_below_pol = POL_ERROR;
  logic [1:0]         map_above_pol = POL_ERROR;
  logic [1:0]         map_miss_mode = MISS_IGNORE;

  // Mirror of the missing-interval table
  logic signed [63:0] gap_lo [16];
  logic signed [63:0] gap_hi [16];
  logic               gap_live [16];

  frame_req_t request_q[$];
  frame_res_t expected_map_q[$];
  frame_req_t on_bus;
  frame_res_t got, want;
  logic       calm = 1'b0;
  int         mismatch_count = 0;

  frame_map_boundary_policy DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic fits64(input logic [127:0] v);
    return v[127:63] == '0 || v[127:63] == '1;
  endfunction

  function automatic logic in_gap(input logic signed [63:0] f);
    for (int i = 0; i < 16; i++) begin
      if (gap_live[i] && f >= gap_lo[i] && f <= gap_hi[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Map a local time onto a source frame and apply the boundary and missing policy
  function automatic frame_res_t resolve_time(input logic signed [63:0] t);
    frame_res_t         r;
    logic signed [127:0] wide_t, wide_s, wide_o, prod, sum;
    logic signed [63:0]  src, bound_f;
    logic                below, in_range, hit;
    logic [1:0]          pol;
    r = '0;
    r.status = ST_OK;
    wide_t = t;
    wide_s = map_step;
    wide_o = map_offset;
    prod = wide_t * wide_s;
    sum = prod + wide_o;
    if (map_step == 0 || !fits64(prod) || !fits64(sum)) begin
      r.status = ST_FAIL;
      return r;
    end
    src = sum[63:0];
    r.src = src;
    r.rd = src;
    if (!map_bounds) return r;
    below = src < map_first;
    in_range = !below && !(map_last < src);
    hit = 1'b0;
    if (!in_range) begin
      pol = below ? map_below_pol : map_above_pol;
      bound_f = below ? map_first : map_last;
      r.status = below ? ST_BEFORE : ST_AFTER;
      if (pol == POL_BLACK) begin
        r.black = 1'b1;
      end else if (pol == POL_HOLD) begin
        if (map_miss_mode != MISS_IGNORE && in_gap(bound_f)) begin
          hit = 1'b1;
        end else begin
          r.rd = bound_f;
          r.hold = 1'b1;
        end
      end else begin
        r.err = 1'b1;
      end
    end else begin
      hit = map_miss_mode != MISS_IGNORE && in_gap(src);
    end
    // A missing frame is black only in black mode, an error otherwise
    if (hit) begin
      r.status = ST_MISSING;
      r.black = map_miss_mode == MISS_BLACK;
      r.err = map_miss_mode != MISS_BLACK;
    end
    return r;
  endfunction

  // Request driver: present queued items, predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        if (on_bus.kind) begin
          expected_map_q.push_back(resolve_time(on_bus.ltime));
        end else begin
          gap_lo[on_bus.slot] = on_bus.lo;
          gap_hi[on_bus.slot] = on_bus.hi;
          gap_live[on_bus.slot] = on_bus.live;
        end
      end
      if (request_q.size() != 0 && !(request_q[0].drain_first && expected_map_q.size() != 0)
          && (calm || $urandom_range(99) >= 12)) begin
        on_bus = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, on_bus.live, on_bus.hi, on_bus.lo, on_bus.slot, on_bus.ltime};
        s_axis_tuser <= on_bus.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.src    = m_axis_tdata[66:3];
        got.rd     = m_axis_tdata[130:67];
        got.black  = m_axis_tdata[131];
        got.err    = m_axis_tdata[132];
        got.hold   = m_axis_tdata[133];
        if (expected_map_q.size() == 0) begin
          $error("result with no request pending: status %0d", got.status);
          mismatch_count++;
        end else begin
          want = expected_map_q.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.src != want.src) begin
            $error("source_frame: expected %h, got %h", want.src, got.src);
            mismatch_count++;
          end
          if (got.rd != want.rd) begin
            $error("read_frame: expected %h, got %h", want.rd, got.rd);
            mismatch_count++;
          end
          if (got.black != want.black) begin
            $error("transparent_black: expected %0d, got %0d", want.black, got.black);
            mismatch_count++;
          end
          if (got.err != want.err) begin
            $error("policy_error: expected %0d, got %0d", want.err, got.err);
            mismatch_count++;
          end
          if (got.hold != want.hold) begin
            $error("hold_applied: expected %0d, got %0d", want.hold, got.hold);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= calm || $urandom_range(99) >= 12;
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [63:0] near(input logic signed [63:0] c, input int span);
    return c + (int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic add_time(input logic signed [63:0] t, input logic drain_first = 1'b0);
    frame_req_t q;
    q = '0;
    q.kind = 1'b1;
    q.ltime = t;
    q.drain_first = drain_first;
    request_q.push_back(q);
  endtask

  task automatic add_hole(input logic [3:0] slot, input logic signed [63:0] lo,
                          input logic signed [63:0] hi, input logic live);
    frame_req_t q;
    q = '0;
    q.slot = slot;
    q.lo = lo;
    q.hi = hi;
    q.live = live;
    request_q.push_back(q);
  endtask

  // Wait until every item is sent and every result is back, then let the block settle;
  // sample between edges so the driver and monitor updates have landed
  task automatic drain();
    do @(negedge clk);
    while (request_q.size() != 0 || s_axis_tvalid || expected_map_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Write a full register set once the block is idle
  task automatic program_map(input logic signed [63:0] off, st, fst, lst, input logic bnd,
                             input logic [1:0] bp, ap, mm);
    drain();
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_STEP, st);
    write_reg(CFG_FIRST, fst);
    write_reg(CFG_LAST, lst);
    write_reg(CFG_BOUNDS, {63'b0, bnd});
    write_reg(CFG_BEFORE, {62'b0, bp});
    write_reg(CFG_AFTER, {62'b0, ap});
    write_reg(CFG_MISSING, {62'b0, mm});
    map_offset = off;
    map_step = st;
    map_first = fst;
    map_last = lst;
    map_bounds = bnd;
    map_below_pol = bp;
    map_above_pol = ap;
    map_miss_mode = mm;
  endtask

  // One random setting followed by a mix of table writes and time requests near the range
  task automatic random_phase(input int n, input logic quiet);
    logic signed [63:0] off, st, fst, lst, tmp, lo;
    int                 r;
    case ($urandom_range(9))
      0: off = FRAME_MAX - int'($urandom_range(40));
      1: off = FRAME_MIN + int'($urandom_range(40));
      default: off = $signed($urandom);
    endcase
    case ($urandom_range(9))
      0: st = 0;
      1: st = rnd64();
      default: st = int'($urandom_range(8)) - 4;
    endcase
    fst = off - int'($urandom_range(30));
    lst = off + int'($urandom_range(30));
    if ($urandom_range(7) == 0) begin
      tmp = fst;
      fst = lst + 1;
      lst = tmp;
    end
    program_map(off, st, fst, lst, $urandom_range(9) != 0, 2'($urandom_range(3)),
                2'($urandom_range(3)), 2'($urandom_range(3)));
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        if ($urandom_range(9) == 0) begin
          add_hole(4'($urandom_range(15)), rnd64(), rnd64(), 1'($urandom_range(1)));
        end else begin
          lo = near(off, 40);
          add_hole(4'($urandom_range(15)), lo, lo + (int'($urandom_range(6)) - 1),
                   $urandom_range(7) != 0);
        end
      end else if (r < 35) begin
        add_time(rnd64(), i == n / 2);
      end else if (r < 40) begin
        case ($urandom_range(3))
          0: add_time(FRAME_MAX, i == n / 2);
          1: add_time(FRAME_MIN, i == n / 2);
          2: add_time(0, i == n / 2);
          default: add_time(-1, i == n / 2);
        endcase
      end else begin
        add_time(int'($urandom_range(30)) - 15, i == n / 2);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) gap_live[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: extremes pass straight through; hole writes incl. inverted and cleared
    add_time(FRAME_MAX);
    add_time(FRAME_MIN);
    add_time(0);
    add_hole(4'd0, 5, 9, 1'b1);
    add_hole(4'd15, 20, 10, 1'b1);
    add_hole(4'd3, FRAME_MIN, FRAME_MAX, 1'b0);
    add_time(7);

    // Zero step fails the mapping
    program_map(0, 0, FRAME_MIN, FRAME_MAX, 1'b0, POL_ERROR, POL_ERROR, MISS_IGNORE);
    add_time(5);

    // Product overflow, and the largest product that still fits
    program_map(0, FRAME_MAX, 0, 0, 1'b0, POL_ERROR, POL_ERROR, MISS_IGNORE);
    add_time(2);
    add_time(-1);

    // Offset overflow
    program_map(FRAME_MAX, 1, 0, 0, 1'b0, POL_ERROR, POL_ERROR, MISS_IGNORE);
    add_time(1);
    add_time(-5);

    // Hold below, unused policy code above, unused missing mode inside
    program_map(0, 1, 0, 30, 1'b1, POL_HOLD, POL_UNUSED, MISS_UNUSED);
    add_time(-5);
    add_time(40);
    add_time(7);
    add_time(20);

    // Boundary frame inside a hole while holding; black above; black missing
    program_map(0, 1, 5, 30, 1'b1, POL_HOLD, POL_BLACK, MISS_BLACK);
    add_time(2);
    add_time(50);
    add_time(6);

    // Inverted range: nothing inside
    program_map(0, 1, 10, 0, 1'b1, POL_ERROR, POL_HOLD, MISS_IGNORE);
    add_time(5);
    add_time(12);
    add_time(-3);

    for (int p = 0; p < 7; p++) random_phase(100, p == 3);
    calm = 1'b0;
    drain();

    if (mismatch_count == 0) begin
      $display("[frame_map_boundary_policy] OK");
    end else begin
      $display("[frame_map_boundary_policy] ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[frame_map_boundary_policy] ERROR");
    $finish;
  end

endmodule
